>>> rtl/core/tfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_pkg
// Shared widths, codes and types of the trajectory similarity block.
// ----------------------------------------------------------------------------
package tfs_pkg;

  localparam int MAX_POINTS_DEF = 256;

  localparam int COORD_W = 16;
  localparam int PT_W    = 2 * COORD_W;  // packed {x, y}
  localparam int DIST_W  = 34;           // squared distance
  localparam int TOL_W   = 15;
  localparam int TOL2_W  = 2 * TOL_W;
  localparam int SIM_W   = 17;
  localparam int STAT_W  = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int ACC_W   = DIST_W + 1;   // divide / root working width
  localparam int Q_W     = 32;

  localparam logic [SIM_W-1:0] SIM_ONE = 17'd65536;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_OVF   = 2'd2;

  // Register map
  localparam logic [PADDR_W-1:0] ADDR_MATCH_TOL = 3'd0;

  // Control of the shared divide / square-root unit
  typedef struct packed {
    logic go;
    logic is_sqrt;
  } ds_ctl_t;

endpackage

>>> rtl/core/tfs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_if
// Valid/ready channels: point items in, similarity items out.
// ----------------------------------------------------------------------------
interface tfs_pt_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic signed [tfs_pkg::COORD_W-1:0]  x;
  logic signed [tfs_pkg::COORD_W-1:0]  y;
  logic                                last;

  modport source(output valid, func, x, y, last, input ready);
  modport sink(input valid, func, x, y, last, output ready);
endinterface

interface tfs_res_if;
  logic                               valid;
  logic                               ready;
  logic [tfs_pkg::SIM_W-1:0]          similarity;
  logic [tfs_pkg::SIM_W-1:0]          path_distance;
  logic                               identical;
  logic [tfs_pkg::STAT_W-1:0]         status;

  modport source(output valid, similarity, path_distance, identical, status,
                 input ready);
  modport sink(input valid, similarity, path_distance, identical, status,
               output ready);
endinterface

>>> rtl/core/trajectory_frechet_similarity_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trajectory_frechet_similarity_top
// Discrete Frechet similarity of two loaded 2-D trajectories.
// ----------------------------------------------------------------------------
// Points load into on-chip stores at one item per cycle while idle; the point
// flagged last on the second trajectory starts the evaluation and the input is
// held off until its item has been handed to the output register. After set-up
// the evaluation runs a pointwise check (only when both trajectories hold the
// same number of points, left early at the first mismatch), the DP (one cell per
// pass: read, delta, square, update through the single DP row memory), the root
// of the Frechet term, the box diagonal, the divide and the root of the ratio,
// all through the shared distance pipeline and the bit-serial divide / root
// unit. Error and identical cases skip the later steps.
// ----------------------------------------------------------------------------
module trajectory_frechet_similarity_top #(
  parameter int MAX_POINTS = tfs_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  tfs_pt_if.sink                        pts,
  tfs_res_if.source                     result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tfs_pkg::PADDR_W-1:0]   paddr,
  input  logic [tfs_pkg::PDATA_W-1:0]   pwdata,
  output logic [tfs_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = tfs_pkg::DIST_W;
  localparam int KW = tfs_pkg::COORD_W;
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_POINTS);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_PREP = 17'h00002,
    S_MRD  = 17'h00004,
    S_MDIF = 17'h00008,
    S_MMUL = 17'h00010,
    S_MCMP = 17'h00020,
    S_CRD  = 17'h00040,
    S_CDIF = 17'h00080,
    S_CMUL = 17'h00100,
    S_CUPD = 17'h00200,
    S_SQF  = 17'h00400,
    S_BDIF = 17'h00800,
    S_BMUL = 17'h01000,
    S_BCMP = 17'h02000,
    S_DIV  = 17'h04000,
    S_SQQ  = 17'h08000,
    S_FIN  = 17'h10000
  } state_t;

  state_t state;

  // configuration
  logic [tfs_pkg::TOL_W-1:0]  match_tol;
  logic [tfs_pkg::TOL2_W-1:0] tol2;

  // trajectory bookkeeping
  logic [CW-1:0]         first_count, second_count;
  logic signed [KW-1:0]  box_min_x, box_max_x, box_min_y, box_max_y;
  logic                  overflow_seen;

  // evaluation
  logic [AW-1:0]         i, j;
  logic [CW-1:0]         n_last, m_last;
  logic [DW-1:0]         left, diag, f2, d2;
  logic [tfs_pkg::Q_W-1:0] q;
  logic                  same;
  logic [tfs_pkg::SIM_W-1:0]  sim_r, fd_r;
  logic                  ident_r;
  logic [tfs_pkg::STAT_W-1:0] stat_r;
  logic                  ds_go;

  // output register
  logic                  res_valid;

  // memory and unit wiring
  logic                  pt_accept, pt_full, pt_we;
  logic [tfs_pkg::PT_W-1:0] a_rdata, b_rdata;
  logic [DW-1:0]         dp_rdata, dist2, best, newv, up_min;
  logic                  dp_we;
  logic signed [KW-1:0]  ax, ay, bx, by;
  logic [DW-1:0]         ds_a;
  logic                  ds_done;
  logic [tfs_pkg::Q_W-1:0] ds_result;
  tfs_pkg::ds_ctl_t      ds_ctl;
  logic                  row_end, col_end;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr == tfs_pkg::ADDR_MATCH_TOL) ?
                  tfs_pkg::PDATA_W'(match_tol) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_tol <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == tfs_pkg::ADDR_MATCH_TOL) begin
      match_tol <= pwdata[tfs_pkg::TOL_W-1:0];
    end
  end

  // point load
  assign pts.ready = (state == S_IDLE);
  assign pt_accept = pts.valid && pts.ready;
  assign pt_full   = pts.func ? (second_count == CNT_FULL) : (first_count == CNT_FULL);
  assign pt_we     = pt_accept && !pt_full;

  // memories
  tfs_pmem #(.MAX_POINTS(MAX_POINTS)) u_pmem (
    .clk      (clk),
    .pt_we    (pt_we),
    .pt_sel   (pts.func),
    .pt_waddr (pts.func ? second_count[AW-1:0] : first_count[AW-1:0]),
    .pt_wdata ({pts.x, pts.y}),
    .a_raddr  (i),
    .b_raddr  (j),
    .a_rdata  (a_rdata),
    .b_rdata  (b_rdata),
    .dp_we    (dp_we),
    .dp_waddr (j),
    .dp_wdata (newv),
    .dp_raddr (j),
    .dp_rdata (dp_rdata)
  );

  // distance operands: stored points, or the box corners for the diagonal
  always_comb begin
    if (state == S_BDIF) begin
      ax = box_max_x;  ay = box_max_y;
      bx = box_min_x;  by = box_min_y;
    end else begin
      ax = a_rdata[tfs_pkg::PT_W-1:KW];  ay = a_rdata[KW-1:0];
      bx = b_rdata[tfs_pkg::PT_W-1:KW];  by = b_rdata[KW-1:0];
    end
  end

  tfs_sqdist u_sqdist (
    .clk   (clk),
    .ax    (ax),
    .ay    (ay),
    .bx    (bx),
    .by    (by),
    .dist2 (dist2)
  );

  // DP cell: dp_rdata is the row above, left and diag are held in registers
  assign up_min = (dp_rdata < left) ? dp_rdata : left;
  always_comb begin
    if (i == '0) begin
      best = (j == '0) ? '0 : left;
    end else if (j == '0) begin
      best = dp_rdata;
    end else begin
      best = (up_min < diag) ? up_min : diag;
    end
  end
  assign newv    = (dist2 > best) ? dist2 : best;
  assign dp_we   = (state == S_CUPD);
  assign row_end = (CW'(j) == m_last);
  assign col_end = (CW'(i) == n_last);

  // shared divide / root
  assign ds_a        = (state == S_SQQ) ? DW'(q) : f2;
  assign ds_ctl.go      = ds_go;
  assign ds_ctl.is_sqrt = (state != S_DIV);

  tfs_divsqrt u_divsqrt (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ds_ctl),
    .a      (ds_a),
    .b      (d2),
    .done   (ds_done),
    .result (ds_result)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      first_count   <= '0;
      second_count  <= '0;
      box_min_x     <= '0;
      box_max_x     <= '0;
      box_min_y     <= '0;
      box_max_y     <= '0;
      overflow_seen <= 1'b0;
      res_valid     <= 1'b0;
      ds_go         <= 1'b0;
    end else begin
      ds_go <= 1'b0;
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (pt_accept) begin
            if (pt_full) begin
              overflow_seen <= 1'b1;
            end else begin
              if (pts.func) begin
                second_count <= second_count + 1'b1;
              end else begin
                first_count <= first_count + 1'b1;
              end
              if (first_count == '0 && second_count == '0) begin
                box_min_x <= pts.x;  box_max_x <= pts.x;
                box_min_y <= pts.y;  box_max_y <= pts.y;
              end else begin
                if (pts.x < box_min_x) box_min_x <= pts.x;
                if (pts.x > box_max_x) box_max_x <= pts.x;
                if (pts.y < box_min_y) box_min_y <= pts.y;
                if (pts.y > box_max_y) box_max_y <= pts.y;
              end
            end
            if (pts.func && pts.last) begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          tol2    <= match_tol * match_tol;
          n_last  <= first_count - 1'b1;
          m_last  <= (second_count == '0) ? '0 : second_count - 1'b1;
          i       <= '0;
          j       <= '0;
          same    <= 1'b0;
          sim_r   <= '0;
          fd_r    <= '0;
          ident_r <= 1'b0;
          stat_r  <= tfs_pkg::STAT_OK;
          if (overflow_seen) begin
            stat_r <= tfs_pkg::STAT_OVF;
            state  <= S_FIN;
          end else if (first_count == '0) begin
            stat_r <= tfs_pkg::STAT_EMPTY;
            state  <= S_FIN;
          end else if (first_count == second_count) begin
            state <= S_MRD;
          end else begin
            state <= S_CRD;
          end
        end
        // pointwise check, pairs (i, i)
        S_MRD:  state <= S_MDIF;
        S_MDIF: state <= S_MMUL;
        S_MMUL: state <= S_MCMP;
        S_MCMP: begin
          if (dist2 > DW'(tol2)) begin
            i     <= '0;
            j     <= '0;
            state <= S_CRD;
          end else if (col_end) begin
            same  <= 1'b1;
            i     <= '0;
            j     <= '0;
            state <= S_CRD;
          end else begin
            i     <= i + 1'b1;
            j     <= j + 1'b1;
            state <= S_MRD;
          end
        end
        // DP, one cell per pass
        S_CRD:  state <= S_CDIF;
        S_CDIF: state <= S_CMUL;
        S_CMUL: state <= S_CUPD;
        S_CUPD: begin
          left <= newv;
          diag <= dp_rdata;
          f2   <= newv;
          if (row_end) begin
            j <= '0;
            if (col_end) begin
              ds_go <= 1'b1;
              state <= S_SQF;
            end else begin
              i     <= i + 1'b1;
              state <= S_CRD;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_CRD;
          end
        end
        S_SQF: begin
          if (ds_done) begin
            fd_r <= ds_result[tfs_pkg::SIM_W-1:0];
            if (same) begin
              sim_r   <= tfs_pkg::SIM_ONE;
              ident_r <= 1'b1;
              state   <= S_FIN;
            end else begin
              state <= S_BDIF;
            end
          end
        end
        // box diagonal and ratio
        S_BDIF: state <= S_BMUL;
        S_BMUL: state <= S_BCMP;
        S_BCMP: begin
          d2 <= dist2;
          if (dist2 < DW'(tol2)) begin
            sim_r <= tfs_pkg::SIM_ONE;
            state <= S_FIN;
          end else if (f2 >= dist2) begin
            sim_r <= '0;
            state <= S_FIN;
          end else begin
            ds_go <= 1'b1;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (ds_done) begin
            q     <= ds_result;
            ds_go <= 1'b1;
            state <= S_SQQ;
          end
        end
        S_SQQ: begin
          if (ds_done) begin
            sim_r <= tfs_pkg::SIM_ONE - ds_result[tfs_pkg::SIM_W-1:0];
            state <= S_FIN;
          end
        end
        // hand over and clear for the next pair
        S_FIN: begin
          if (!res_valid) begin
            res_valid               <= 1'b1;
            result.similarity       <= sim_r;
            result.path_distance    <= fd_r;
            result.identical        <= ident_r;
            result.status           <= stat_r;
            first_count             <= '0;
            second_count            <= '0;
            box_min_x               <= '0;
            box_max_x               <= '0;
            box_min_y               <= '0;
            box_max_y               <= '0;
            overflow_seen           <= 1'b0;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid = res_valid;

endmodule

>>> rtl/core/tfs_pmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_pmem
// Point stores of both trajectories and the DP row, with registered reads.
// ----------------------------------------------------------------------------
module tfs_pmem #(
  parameter int MAX_POINTS = tfs_pkg::MAX_POINTS_DEF,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  logic                         clk,
  input  logic                         pt_we,
  input  logic                         pt_sel,    // 0 first, 1 second
  input  logic [AW-1:0]                pt_waddr,
  input  logic [tfs_pkg::PT_W-1:0]     pt_wdata,
  input  logic [AW-1:0]                a_raddr,
  input  logic [AW-1:0]                b_raddr,
  output logic [tfs_pkg::PT_W-1:0]     a_rdata,
  output logic [tfs_pkg::PT_W-1:0]     b_rdata,
  input  logic                         dp_we,
  input  logic [AW-1:0]                dp_waddr,
  input  logic [tfs_pkg::DIST_W-1:0]   dp_wdata,
  input  logic [AW-1:0]                dp_raddr,
  output logic [tfs_pkg::DIST_W-1:0]   dp_rdata
);

  logic [tfs_pkg::PT_W-1:0]   first_mem  [MAX_POINTS];
  logic [tfs_pkg::PT_W-1:0]   second_mem [MAX_POINTS];
  logic [tfs_pkg::DIST_W-1:0] dp_mem     [MAX_POINTS];

  // first trajectory
  always_ff @(posedge clk) begin
    if (pt_we && !pt_sel) begin
      first_mem[pt_waddr] <= pt_wdata;
    end
    a_rdata <= first_mem[a_raddr];
  end

  // second trajectory
  always_ff @(posedge clk) begin
    if (pt_we && pt_sel) begin
      second_mem[pt_waddr] <= pt_wdata;
    end
    b_rdata <= second_mem[b_raddr];
  end

  // DP row
  always_ff @(posedge clk) begin
    if (dp_we) begin
      dp_mem[dp_waddr] <= dp_wdata;
    end
    dp_rdata <= dp_mem[dp_raddr];
  end

endmodule

>>> rtl/core/tfs_sqdist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_sqdist
// Two-stage squared Euclidean distance: absolute deltas, then squares.
// ----------------------------------------------------------------------------
module tfs_sqdist (
  input  logic                                clk,
  input  logic signed [tfs_pkg::COORD_W-1:0]  ax,
  input  logic signed [tfs_pkg::COORD_W-1:0]  ay,
  input  logic signed [tfs_pkg::COORD_W-1:0]  bx,
  input  logic signed [tfs_pkg::COORD_W-1:0]  by,
  output logic [tfs_pkg::DIST_W-1:0]          dist2
);

  localparam int CW = tfs_pkg::COORD_W;

  logic signed [CW:0] diff_x, diff_y;
  logic [CW-1:0]      dx, dy;
  logic [2*CW-1:0]    sq_x, sq_y;

  assign diff_x = {ax[CW-1], ax} - {bx[CW-1], bx};
  assign diff_y = {ay[CW-1], ay} - {by[CW-1], by};

  // stage 1: magnitudes fit in CW bits unsigned
  always_ff @(posedge clk) begin
    dx <= diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
    dy <= diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];
  end

  // stage 2: squares
  always_ff @(posedge clk) begin
    sq_x <= dx * dx;
    sq_y <= dy * dy;
  end

  assign dist2 = tfs_pkg::DIST_W'(sq_x) + tfs_pkg::DIST_W'(sq_y);

endmodule

>>> rtl/core/tfs_divsqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_divsqrt
// Iterative unit: fractional divide (32 quotient bits) or integer square root
// (17 root bits), one bit per cycle.
// ----------------------------------------------------------------------------
module tfs_divsqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  tfs_pkg::ds_ctl_t              ctl,
  input  logic [tfs_pkg::DIST_W-1:0]    a,      // dividend or radicand
  input  logic [tfs_pkg::DIST_W-1:0]    b,      // divisor
  output logic                          done,
  output logic [tfs_pkg::Q_W-1:0]       result
);

  localparam int AW = tfs_pkg::ACC_W;
  localparam logic [AW-1:0] SQ_BIT0  = AW'(1) << (tfs_pkg::DIST_W - 2);
  localparam logic [AW-1:0] DIV_BIT0 = AW'(1) << (tfs_pkg::Q_W - 1);

  logic                        busy;
  logic                        sqrt_mode;
  logic [AW-1:0]               rem;
  logic [AW-1:0]               acc;
  logic [AW-1:0]               bitv;
  logic [tfs_pkg::DIST_W-1:0]  den;
  logic [AW-1:0]               trial;
  logic [AW-1:0]               rem2;

  assign trial  = acc + bitv;
  assign rem2   = {rem[AW-2:0], 1'b0};
  assign result = acc[tfs_pkg::Q_W-1:0];

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.go) begin
        busy <= 1'b1;
      end else if (busy && bitv == AW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      sqrt_mode <= ctl.is_sqrt;
      rem       <= AW'(a);
      den       <= b;
      acc       <= '0;
      bitv      <= ctl.is_sqrt ? SQ_BIT0 : DIV_BIT0;
    end else if (busy) begin
      if (sqrt_mode) begin
        // restoring root: one result bit per step
        if (rem >= trial) begin
          rem <= rem - trial;
          acc <= (acc >> 1) + bitv;
        end else begin
          acc <= acc >> 1;
        end
        bitv <= bitv >> 2;
      end else begin
        // restoring division of a fraction below one
        if (rem2 >= AW'(den)) begin
          rem <= rem2 - AW'(den);
          acc <= {acc[AW-2:0], 1'b1};
        end else begin
          rem <= rem2;
          acc <= {acc[AW-2:0], 1'b0};
        end
        bitv <= bitv >> 1;
      end
    end
  end

endmodule

>>> rtl/core/tfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfs_checker
// Port-level checks on result items, bound to the top level.
// ----------------------------------------------------------------------------
module tfs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tfs_pkg::SIM_W-1:0]     similarity,
  input logic [tfs_pkg::SIM_W-1:0]     path_distance,
  input logic                          identical,
  input logic [tfs_pkg::STAT_W-1:0]    status
);

  // a stalled item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(similarity) && $stable(status))
    else $error("result item changed while stalled");

  // error items carry no measurements
  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != tfs_pkg::STAT_OK |->
      similarity == '0 && path_distance == '0 && !identical)
    else $error("error item carries data");

  // identical trajectories give full similarity
  a_ident: assert property (@(posedge clk) disable iff (rst)
    out_valid && identical |-> similarity == tfs_pkg::SIM_ONE &&
                               status == tfs_pkg::STAT_OK)
    else $error("identical item without full similarity");

  // range of the result
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> similarity <= tfs_pkg::SIM_ONE &&
                  (status == tfs_pkg::STAT_OK || status == tfs_pkg::STAT_EMPTY ||
                   status == tfs_pkg::STAT_OVF))
    else $error("result out of range");

endmodule

bind trajectory_frechet_similarity_top tfs_checker u_tfs_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .similarity       (result.similarity),
  .path_distance    (result.path_distance),
  .identical        (result.identical),
  .status           (result.status)
);
